/* rtl/vertical_surface_pixel_filter_defines.svh */
// Assertion macros shared by the filter's modules.
`ifndef VERTICAL_SURFACE_PIXEL_FILTER_DEFINES_SVH
`define VERTICAL_SURFACE_PIXEL_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define VSPF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VSPF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define VSPF_ASSERT(lbl, clk, rst_n, prop, msg)
`define VSPF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

/* rtl/vspf_pkg.sv */
`default_nettype none

package vspf_pkg;

  localparam int LINE_WIDTH = 1024;
  localparam int LB_AW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

  // Queue between front and back, and the result buffer at the output.
  localparam int QDEPTH = 4;
  localparam int ODEPTH = 4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINE_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINE_MAX = 2'd2;

  localparam logic signed [15:0] SINE_MAX_RST = 16'sd16384;

  typedef logic [LB_AW-1:0] lb_idx_t;
  typedef logic [$clog2(QDEPTH)-1:0] qptr_t;
  typedef logic [$clog2(QDEPTH+1)-1:0] qcnt_t;
  typedef logic [$clog2(ODEPTH)-1:0] optr_t;
  typedef logic [$clog2(ODEPTH+1)-1:0] ocnt_t;

  typedef struct packed {
    logic [9:0]         column;
    logic               first_row;
    logic               last_row;
    logic               valid_req;
    logic signed [15:0] x_mm;
    logic signed [15:0] z_mm;
    logic [15:0]        depth_mm;
  } pix_in_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic        for_row_above;
    logic        vertical;
    logic [15:0] depth_out;
    logic        last;
  } pix_out_t;

  // Pixel after classification in the front part.
  typedef struct packed {
    pix_in_t pix;
    logic    in_range;
    lb_idx_t idx;
  } pix_cls_t;

  typedef struct packed {
    logic signed [15:0] camera_x_mm;
    logic signed [15:0] sine_min;
    logic signed [15:0] sine_max;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/vspf_front.sv */
`default_nettype none

module vspf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vspf_pkg::pix_in_t  in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output vspf_pkg::pix_cls_t q_data_o
);

  logic               fr_valid_q, fr_valid_d;
  vspf_pkg::pix_cls_t fr_q;
  vspf_pkg::pix_cls_t cls;
  logic               take;

  assign in_stall_o = fr_valid_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign q_push_o   = fr_valid_q && !q_full_i;
  assign q_data_o   = fr_q;

  // Columns beyond the line buffer never write it, and what is read for them goes unused.
  always_comb begin
    cls.pix      = in_data_i;
    cls.in_range = (32'(in_data_i.column) < vspf_pkg::LINE_WIDTH);
    cls.idx      = vspf_pkg::lb_idx_t'(in_data_i.column);
  end

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (take) begin
      fr_valid_d = 1'b1;
    end else if (q_push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fr_q <= cls;
    end
  end

endmodule

`default_nettype wire

/* rtl/vspf_queue.sv */
`default_nettype none
`include "vertical_surface_pixel_filter_defines.svh"

module vspf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vspf_pkg::pix_cls_t push_data_i,
  input  logic               pop_i,
  output vspf_pkg::pix_cls_t head_o,
  output logic               full_o,
  output logic               empty_o
);

  vspf_pkg::pix_cls_t slots_q [vspf_pkg::QDEPTH];
  vspf_pkg::qptr_t    wp_q, rp_q;
  vspf_pkg::qcnt_t    cnt_q, cnt_d;

  assign full_o  = (cnt_q == vspf_pkg::qcnt_t'(vspf_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + vspf_pkg::qcnt_t'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - vspf_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wp_q <= wp_q + vspf_pkg::qptr_t'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + vspf_pkg::qptr_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wp_q] <= push_data_i;
    end
  end

  `VSPF_ASSERT(a_q_no_overflow, clk_i, rst_ni, push_i |-> !full_o, "queue push while full")
  `VSPF_ASSERT(a_q_no_underflow, clk_i, rst_ni, pop_i |-> !empty_o, "queue pop while empty")

endmodule

`default_nettype wire

/* rtl/vspf_back.sv */
`default_nettype none
`include "vertical_surface_pixel_filter_defines.svh"

module vspf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vspf_pkg::cfg_t     cfg_i,
  input  logic               q_empty_i,
  input  vspf_pkg::pix_cls_t q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vspf_pkg::pix_out_t out_data_o
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] z;
    logic               valid;
    logic [15:0]        depth;
    logic               marked;
  } lb_entry_t;

  typedef struct packed {
    vspf_pkg::pix_cls_t it;
    logic [15:0]        ad;
    logic               am;
    logic               nz_neg;
    logic               elig;
  } carry_t;

  typedef struct packed {
    logic              we;
    vspf_pkg::lb_idx_t idx;
    logic              marked;
  } mk_hist_t;

  // Line buffer: row above, one entry per column.
  lb_entry_t lb_mem [vspf_pkg::LINE_WIDTH];
  lb_entry_t rd_q;

  logic               adv, fire;
  logic [4:0]         vld_q;
  vspf_pkg::pix_cls_t it1_q;
  carry_t             cry_q [4];
  carry_t             cry_d;
  carry_t             c5;
  mk_hist_t           mkh_q [5];
  lb_entry_t          lw_q;
  lb_entry_t          fw;
  lb_entry_t          wr_entry;

  logic signed [16:0] dx, dz;
  logic [16:0]        mdx_w, mdz_w;
  logic               nz_neg_w, elig_w;

  logic [15:0] mdx_q, mdz_q;
  logic [31:0] sqx3_q, sqz3_q;
  logic [31:0] sqx4_q;
  logic [32:0] n2_q;
  logic [31:0] sqx5_q;
  logic [47:0] ppl_min_q, ppl_max_q;
  logic [46:0] pph_min_q, pph_max_q;

  logic [15:0] smn_mag, smx_mag;
  logic [31:0] smn_sq_w, smx_sq_w;
  logic [30:0] smn_sq_q, smx_sq_q;

  logic [63:0] lhs, rhs_min, rhs_max;
  logic        fail_min, fail_max, pair, am_fw, am;

  vspf_pkg::pix_out_t r_abv, r_cur, res_a;
  logic               push_a, push_b;
  logic [1:0]         npush;
  logic               pop;

  vspf_pkg::pix_out_t ofifo_q [vspf_pkg::ODEPTH];
  vspf_pkg::optr_t    owp_q, owp1, orp_q;
  vspf_pkg::ocnt_t    oc_q, oc_d;

  function automatic logic sm_less(input logic an, input logic [63:0] am_v,
                                   input logic bn, input logic [63:0] bm_v);
    logic a_neg, b_neg, res;
    a_neg = an && (am_v != '0);
    b_neg = bn && (bm_v != '0);
    if (a_neg != b_neg) begin
      res = a_neg;
    end else if (!a_neg) begin
      res = am_v < bm_v;
    end else begin
      res = am_v > bm_v;
    end
    return res;
  endfunction

  // The whole back pipeline moves only when the result buffer has room for two.
  assign adv     = (oc_q <= vspf_pkg::ocnt_t'(vspf_pkg::ODEPTH - 2));
  assign q_pop_o = adv && !q_empty_i;
  assign fire    = adv && vld_q[4];
  assign c5      = cry_q[3];

  // Threshold squares are registered and follow the configuration registers in the cycle after.
  assign smn_mag  = cfg_i.sine_min[15] ? 16'(-cfg_i.sine_min) : 16'(cfg_i.sine_min);
  assign smx_mag  = cfg_i.sine_max[15] ? 16'(-cfg_i.sine_max) : 16'(cfg_i.sine_max);
  assign smn_sq_w = smn_mag * smn_mag;
  assign smx_sq_w = smx_mag * smx_mag;

  always_ff @(posedge clk_i) begin
    smn_sq_q <= smn_sq_w[30:0];
    smx_sq_q <= smx_sq_w[30:0];
  end

  // Stage 1: the read took the memory as it was at the pop, so pending
  // writes of older pixels in later stages, and the write made at that same
  // edge, take precedence. The youngest older pixel wins.
  always_comb begin
    fw = rd_q;
    if (mkh_q[0].we && (mkh_q[0].idx == it1_q.idx)) begin
      fw = lw_q;
    end
    for (int k = 3; k >= 0; k--) begin
      if (vld_q[k+1] && cry_q[k].it.in_range && (cry_q[k].it.idx == it1_q.idx)) begin
        fw.x     = cry_q[k].it.pix.x_mm;
        fw.z     = cry_q[k].it.pix.z_mm;
        fw.valid = cry_q[k].it.pix.valid_req;
        fw.depth = cry_q[k].it.pix.depth_mm;
      end
    end
  end

  assign dx    = {it1_q.pix.x_mm[15], it1_q.pix.x_mm} - {fw.x[15], fw.x};
  assign dz    = {it1_q.pix.z_mm[15], it1_q.pix.z_mm} - {fw.z[15], fw.z};
  assign mdx_w = dx[16] ? (~dx + 17'd1) : dx;
  assign mdz_w = dz[16] ? (~dz + 17'd1) : dz;

  always_comb begin
    if (it1_q.pix.x_mm > cfg_i.camera_x_mm) begin
      nz_neg_w = !dx[16] && (dx != '0);
    end else begin
      nz_neg_w = dx[16];
    end
    elig_w = !it1_q.pix.first_row && it1_q.in_range && it1_q.pix.valid_req
             && fw.valid && dz[16];
    cry_d.it     = it1_q;
    cry_d.ad     = fw.depth;
    cry_d.am     = fw.marked;
    cry_d.nz_neg = nz_neg_w;
    cry_d.elig   = elig_w;
  end

  // Stage 5: signed-square comparison against both thresholds.
  assign lhs     = {4'b0, sqx5_q, 28'b0};
  assign rhs_min = {16'b0, ppl_min_q} + {pph_min_q, 17'b0};
  assign rhs_max = {16'b0, ppl_max_q} + {pph_max_q, 17'b0};

  always_comb begin
    fail_min = sm_less(c5.nz_neg, lhs, cfg_i.sine_min[15], rhs_min);
    fail_max = sm_less(cfg_i.sine_max[15], rhs_max, c5.nz_neg, lhs);
    pair     = c5.elig && !fail_min && !fail_max;
    // A mark set by a pixel that wrote after this pixel's read overrides it.
    am_fw = c5.am;
    for (int k = 4; k >= 0; k--) begin
      if (mkh_q[k].we && (mkh_q[k].idx == c5.it.idx)) begin
        am_fw = mkh_q[k].marked;
      end
    end
    am = c5.it.in_range && (am_fw || pair);
  end

  always_comb begin
    wr_entry.x      = c5.it.pix.x_mm;
    wr_entry.z      = c5.it.pix.z_mm;
    wr_entry.valid  = c5.it.pix.valid_req;
    wr_entry.depth  = c5.it.pix.depth_mm;
    wr_entry.marked = pair;

    r_abv.out_column    = c5.it.pix.column;
    r_abv.for_row_above = 1'b1;
    r_abv.vertical      = am;
    r_abv.depth_out     = am ? c5.ad : 16'd0;
    r_abv.last          = !c5.it.pix.last_row;

    r_cur.out_column    = c5.it.pix.column;
    r_cur.for_row_above = 1'b0;
    r_cur.vertical      = pair;
    r_cur.depth_out     = pair ? c5.it.pix.depth_mm : 16'd0;
    r_cur.last          = 1'b1;

    res_a  = c5.it.pix.first_row ? r_cur : r_abv;
    push_a = fire && (!c5.it.pix.first_row || c5.it.pix.last_row);
    push_b = fire && !c5.it.pix.first_row && c5.it.pix.last_row;
  end

  // Line buffer ports: read at the pop, write when the pixel leaves stage 5.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= lb_mem[q_head_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && c5.it.in_range) begin
      lb_mem[c5.it.idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      for (int k = 0; k < 5; k++) begin
        mkh_q[k] <= '0;
      end
    end else if (adv) begin
      vld_q       <= {vld_q[3:0], q_pop_o};
      mkh_q[0].we     <= vld_q[4] && c5.it.in_range;
      mkh_q[0].idx    <= c5.it.idx;
      mkh_q[0].marked <= pair;
      for (int k = 1; k < 5; k++) begin
        mkh_q[k] <= mkh_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q    <= q_head_i;
      lw_q     <= wr_entry;
      cry_q[0] <= cry_d;
      for (int k = 1; k < 4; k++) begin
        cry_q[k] <= cry_q[k-1];
      end
      mdx_q     <= mdx_w[15:0];
      mdz_q     <= mdz_w[15:0];
      sqx3_q    <= mdx_q * mdx_q;
      sqz3_q    <= mdz_q * mdz_q;
      sqx4_q    <= sqx3_q;
      n2_q      <= {1'b0, sqx3_q} + {1'b0, sqz3_q};
      sqx5_q    <= sqx4_q;
      ppl_min_q <= smn_sq_q * n2_q[16:0];
      pph_min_q <= smn_sq_q * n2_q[32:17];
      ppl_max_q <= smx_sq_q * n2_q[16:0];
      pph_max_q <= smx_sq_q * n2_q[32:17];
    end
  end

  // Result buffer: up to two writes and one read a cycle.
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (oc_q != '0);
  assign out_data_o  = ofifo_q[orp_q];
  assign owp1        = owp_q + vspf_pkg::optr_t'(1);
  assign npush       = {1'b0, push_a} + {1'b0, push_b};
  assign oc_d        = oc_q + vspf_pkg::ocnt_t'(npush) - vspf_pkg::ocnt_t'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q <= '0;
      orp_q <= '0;
      oc_q  <= '0;
    end else begin
      oc_q  <= oc_d;
      owp_q <= owp_q + vspf_pkg::optr_t'(npush);
      if (pop) begin
        orp_q <= orp_q + vspf_pkg::optr_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a) begin
      ofifo_q[owp_q] <= res_a;
    end
    if (push_b) begin
      ofifo_q[owp1] <= r_cur;
    end
  end

  `VSPF_ASSERT(a_obuf_bound, clk_i, rst_ni, oc_q <= vspf_pkg::ocnt_t'(vspf_pkg::ODEPTH), "result buffer overflow")
  `VSPF_ASSERT_NEXT(a_pipe_hold, clk_i, rst_ni, !adv, $stable(vld_q), "pipeline moved while held")
  `VSPF_ASSERT(a_pair_src, clk_i, rst_ni, (fire && pair) |-> (c5.it.pix.valid_req && !c5.it.pix.first_row && c5.it.in_range), "pixel marked without a valid pair")

endmodule

`default_nettype wire

/* rtl/vertical_surface_pixel_filter.sv */
// Channel  Dir  Handshake                    Payload
// in       in   in_valid_i / in_stall_o      in_data_i   (vspf_pkg::pix_in_t)
// out      out  out_valid_o / out_stall_i    out_data_o  (vspf_pkg::pix_out_t)
// cfg      in   cfg_we_i, cfg_idx_i          cfg_data_i  (16 bits, no read-back)
//
// One pixel per clock is accepted while in_stall_o is low; a bottom-row pixel with a row
// above gives two results. On its way out a pixel passes the front register, the queue,
// five back stages around the one-read one-write line buffer, and the result buffer.
// Reset is asynchronous and clears control state; the line buffer is not cleared.
// An output stall holds the back stages once the result buffer has fewer than two
// free slots, while the queue keeps taking pixels until it fills.
`default_nettype none

module vertical_surface_pixel_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  vspf_pkg::pix_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output vspf_pkg::pix_out_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [vspf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [15:0]                         cfg_data_i
);

  vspf_pkg::cfg_t     cfg_q;
  logic               q_push, q_pop, q_full, q_empty;
  vspf_pkg::pix_cls_t q_in, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x_mm <= '0;
      cfg_q.sine_min    <= '0;
      cfg_q.sine_max    <= vspf_pkg::SINE_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vspf_pkg::CFG_CAMERA_X: cfg_q.camera_x_mm <= cfg_data_i;
        vspf_pkg::CFG_SINE_MIN: cfg_q.sine_min    <= cfg_data_i;
        vspf_pkg::CFG_SINE_MAX: cfg_q.sine_max    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vspf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  vspf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  vspf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/vertical_surface_pixel_filter_tb.sv */
`default_nettype none

module vertical_surface_pixel_filter_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 255;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    vspf_pkg::pix_in_t  pix;
    logic               has_lit;
    vspf_pkg::pix_out_t lit;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  vspf_pkg::pix_in_t  in_data;
  logic               out_valid;
  logic               out_stall;
  vspf_pkg::pix_out_t out_data;
  logic               cfg_we;
  logic [vspf_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [15:0]        cfg_data;

  // Shadow of the filter: thresholds and the row-above line buffer.
  logic signed [15:0] cam_x;
  logic signed [15:0] s_min;
  logic signed [15:0] s_max;
  logic signed [15:0] lb_x [vspf_pkg::LINE_WIDTH];
  logic signed [15:0] lb_z [vspf_pkg::LINE_WIDTH];
  logic [15:0]        lb_depth [vspf_pkg::LINE_WIDTH];
  bit                 lb_valid [vspf_pkg::LINE_WIDTH];
  bit                 lb_marked [vspf_pkg::LINE_WIDTH];
  bit                 col_written [vspf_pkg::LINE_WIDTH];

  vspf_pkg::pix_out_t marks_due[$];
  dir_row_t           dir_tab[$];
  int                 mismatches;
  int                 cycles;
  int                 sent;
  bit                 in_quiet;

  vertical_surface_pixel_filter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Compares two signed values held as sign and magnitude.
  function automatic int sm_order(bit an, bit [63:0] am, bit bn, bit [63:0] bm);
    bit a_neg;
    bit b_neg;
    a_neg = an && (am != 0);
    b_neg = bn && (bm != 0);
    if (a_neg != b_neg) return a_neg ? -1 : 1;
    if (am == bm) return 0;
    if (!a_neg) return (am > bm) ? 1 : -1;
    return (am > bm) ? -1 : 1;
  endfunction

  // Squared comparison of the normal component against both sine bounds.
  function automatic bit surface_pair(logic signed [15:0] x, logic signed [15:0] z,
                                      logic signed [15:0] ax, logic signed [15:0] az);
    int dx;
    int dz;
    int nz;
    int smin_i;
    int smax_i;
    bit [63:0] mdx;
    bit [63:0] mdz;
    bit [63:0] mnz;
    bit [63:0] n2;
    bit [63:0] lhs;
    bit [63:0] smn;
    bit [63:0] smx;
    dx = int'(x) - int'(ax);
    dz = int'(z) - int'(az);
    if (dz >= 0) return 1'b0;
    nz = (x > cam_x) ? -dx : dx;
    mdx = 64'((dx < 0) ? -dx : dx);
    mdz = 64'((dz < 0) ? -dz : dz);
    mnz = 64'((nz < 0) ? -nz : nz);
    n2 = mdx * mdx + mdz * mdz;
    lhs = (mnz * mnz) << 28;
    smin_i = int'(s_min);
    smax_i = int'(s_max);
    smn = 64'((smin_i < 0) ? -smin_i : smin_i);
    smx = 64'((smax_i < 0) ? -smax_i : smax_i);
    if (sm_order(nz < 0, lhs, smin_i < 0, smn * smn * n2) < 0) return 1'b0;
    if (sm_order(nz < 0, lhs, smax_i < 0, smx * smx * n2) > 0) return 1'b0;
    return 1'b1;
  endfunction

  // Updates the shadow line buffer and queues the results this pixel releases.
  task automatic classify_pixel(input vspf_pkg::pix_in_t p);
    bit                 pair;
    bit                 above_mark;
    vspf_pkg::pix_out_t r;
    int                 c;
    c = int'(p.column);
    pair = 1'b0;
    if (!p.first_row) begin
      if (p.valid_req && lb_valid[c])
        pair = surface_pair(p.x_mm, p.z_mm, lb_x[c], lb_z[c]);
      above_mark = lb_marked[c] || pair;
      r.out_column    = p.column;
      r.for_row_above = 1'b1;
      r.vertical      = above_mark;
      r.depth_out     = above_mark ? lb_depth[c] : 16'd0;
      r.last          = !p.last_row;
      marks_due = {marks_due, r};
    end
    lb_x[c]        = p.x_mm;
    lb_z[c]        = p.z_mm;
    lb_valid[c]    = p.valid_req;
    lb_depth[c]    = p.depth_mm;
    lb_marked[c]   = pair;
    col_written[c] = 1'b1;
    if (p.last_row) begin
      r.out_column    = p.column;
      r.for_row_above = 1'b0;
      r.vertical      = pair;
      r.depth_out     = pair ? p.depth_mm : 16'd0;
      r.last          = 1'b1;
      marks_due = {marks_due, r};
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (in_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // A typed-in result replaces the predicted one for rows where it is obvious.
  task automatic send_pixel(input vspf_pkg::pix_in_t p, input bit has_lit,
                            input vspf_pkg::pix_out_t lit);
    int gap;
    int depth_before;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    depth_before = marks_due.size();
    classify_pixel(p);
    if (has_lit) begin
      while (marks_due.size() > depth_before) void'(marks_due.pop_back());
      marks_due = {marks_due, lit};
    end
  endtask

  // A pixel below a column that was never filled is turned into a top-row pixel.
  function automatic vspf_pkg::pix_in_t legal_pixel(vspf_pkg::pix_in_t p);
    if (!p.first_row && !col_written[p.column]) p.first_row = 1'b1;
    return p;
  endfunction

  function automatic vspf_pkg::pix_in_t px(int col, bit first, bit lastr, bit valid,
                                           int x, int z, int depth);
    vspf_pkg::pix_in_t p;
    p.column    = 10'(col);
    p.first_row = first;
    p.last_row  = lastr;
    p.valid_req = valid;
    p.x_mm      = 16'(x);
    p.z_mm      = 16'(z);
    p.depth_mm  = 16'(depth);
    return p;
  endfunction

  function automatic vspf_pkg::pix_out_t po(int col, bit above, bit vert, int depth,
                                            bit lastr);
    vspf_pkg::pix_out_t r;
    r.out_column    = 10'(col);
    r.for_row_above = above;
    r.vertical      = vert;
    r.depth_out     = 16'(depth);
    r.last          = lastr;
    return r;
  endfunction

  task automatic add_row(input vspf_pkg::pix_in_t p, input bit has_lit,
                         input vspf_pkg::pix_out_t lit);
    dir_row_t row;
    row.pix     = p;
    row.has_lit = has_lit;
    row.lit     = lit;
    dir_tab = {dir_tab, row};
  endtask

  task automatic run_directed();
    // Single-row frames at both ends of the line, extreme coordinates.
    add_row(px(0, 1, 1, 1, 32767, -32768, 65535), 1'b1, po(0, 0, 0, 0, 1));
    add_row(px(1023, 1, 1, 1, 32767, 32767, 65535), 1'b1, po(1023, 0, 0, 0, 1));
    // Largest possible drop in both axes below the previous pixel.
    add_row(px(1023, 0, 1, 1, -32768, -32768, 65535), 1'b0, '0);
    // A small three-row frame: straight wall, tilted wall, invalid above, rising z.
    add_row(px(10, 1, 0, 1, 100, 1000, 500), 1'b0, '0);
    add_row(px(11, 1, 0, 1, -100, 1000, 600), 1'b0, '0);
    add_row(px(12, 1, 0, 0, 0, 0, 700), 1'b0, '0);
    add_row(px(13, 1, 0, 1, 0, 0, 800), 1'b0, '0);
    add_row(px(10, 0, 0, 1, 100, 500, 510), 1'b0, '0);
    add_row(px(11, 0, 0, 1, -50, 500, 610), 1'b0, '0);
    add_row(px(12, 0, 0, 1, 0, -20, 710), 1'b0, '0);
    add_row(px(13, 0, 0, 1, 10, 10, 810), 1'b0, '0);
    add_row(px(10, 0, 1, 1, 100, 0, 520), 1'b0, '0);
    add_row(px(11, 0, 1, 0, -50, 0, 620), 1'b0, '0);
    add_row(px(12, 0, 1, 1, -32768, -30000, 720), 1'b0, '0);
    add_row(px(13, 0, 1, 1, 32767, -32768, 820), 1'b0, '0);
    // An invalid pixel under an unmarked one releases an unmarked result.
    add_row(px(0, 0, 0, 0, -1, -1, 0), 1'b1, po(0, 1, 0, 0, 1));
    add_row(px(0, 0, 1, 1, 0, -5, 1234), 1'b0, '0);
    foreach (dir_tab[i]) send_pixel(dir_tab[i].pix, dir_tab[i].has_lit, dir_tab[i].lit);
  endtask

  // Row-major frame over a random window of columns, mostly falling walls.
  task automatic run_frame();
    int w;
    int c0;
    int rows;
    bit broken;
    logic signed [15:0] fx [48];
    logic signed [15:0] fz [48];
    vspf_pkg::pix_in_t p;
    w = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 48);
    c0 = $urandom_range(0, vspf_pkg::LINE_WIDTH - w);
    rows = $urandom_range(1, 6);
    broken = ($urandom_range(0, 9) == 0);
    in_quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < w; i++) begin
      fx[i] = $urandom_range(0, 1) ? 16'($urandom)
                                   : 16'($urandom_range(0, 6000)) - 16'd3000;
      fz[i] = 16'($urandom);
    end
    for (int r = 0; r < rows; r++) begin
      for (int i = 0; i < w; i++) begin
        if (r > 0) begin
          if ($urandom_range(0, 19) == 0) begin
            fx[i] = 16'($urandom);
            fz[i] = 16'($urandom);
          end else begin
            fx[i] = fx[i] + 16'($urandom_range(0, 400)) - 16'd200;
            if ($urandom_range(0, 4) != 0) fz[i] = fz[i] - 16'($urandom_range(0, 600));
            else fz[i] = fz[i] + 16'($urandom_range(0, 300));
          end
        end
        if (broken && $urandom_range(0, 9) == 0) continue;
        p.column    = 10'(c0 + i);
        p.first_row = (r == 0);
        p.last_row  = (r == rows - 1);
        p.valid_req = ($urandom_range(0, 99) < 85);
        p.x_mm      = fx[i];
        p.z_mm      = fz[i];
        p.depth_mm  = 16'($urandom);
        send_pixel(legal_pixel(p), 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic run_noise();
    int n;
    vspf_pkg::pix_in_t p;
    n = $urandom_range(1, 8);
    repeat (n) begin
      p = $bits(vspf_pkg::pix_in_t)'({$urandom, $urandom});
      send_pixel(legal_pixel(p), 1'b0, '0);
      sent++;
    end
  endtask

  task automatic load_thresholds(input logic [15:0] cam, input logic [15:0] smin,
                                 input logic [15:0] smax);
    cfg_we   <= 1'b1;
    cfg_idx  <= vspf_pkg::CFG_CAMERA_X;
    cfg_data <= cam;
    @(posedge clk);
    cam_x = cam;
    cfg_idx  <= vspf_pkg::CFG_SINE_MIN;
    cfg_data <= smin;
    @(posedge clk);
    s_min = smin;
    cfg_idx  <= vspf_pkg::CFG_SINE_MAX;
    cfg_data <= smax;
    @(posedge clk);
    s_max = smax;
    cfg_we <= 1'b0;
  endtask

  // Pixels without a result may still be in flight after the last result.
  task automatic settle();
    in_valid <= 1'b0;
    while (marks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    vspf_pkg::pix_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (marks_due.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        mismatches++;
      end else begin
        want = marks_due.pop_front();
        if (out_data.out_column !== want.out_column) begin
          $error("out_column: expected %0d, got %0d", want.out_column, out_data.out_column);
          mismatches++;
        end
        if (out_data.for_row_above !== want.for_row_above) begin
          $error("for_row_above: expected %0d, got %0d", want.for_row_above,
                 out_data.for_row_above);
          mismatches++;
        end
        if (out_data.vertical !== want.vertical) begin
          $error("vertical: expected %0d, got %0d", want.vertical, out_data.vertical);
          mismatches++;
        end
        if (out_data.depth_out !== want.depth_out) begin
          $error("depth_out: expected %0d, got %0d", want.depth_out, out_data.depth_out);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  // Output back-pressure: bursts of stall with free stretches of varied length.
  initial begin
    int run;
    int hold;
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) run = $urandom_range(1, 3);
      else if (r < 85) run = $urandom_range(4, 12);
      else if (r < 95) run = $urandom_range(20, 60);
      else run = $urandom_range(200, 400);
      r = $urandom_range(0, 99);
      if (r < 70) hold = $urandom_range(1, 2);
      else if (r < 95) hold = $urandom_range(3, 8);
      else hold = $urandom_range(20, 40);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    int smin_i;
    int smax_i;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= vspf_pkg::CFG_CAMERA_X;
    cfg_data   <= '0;
    cycles     = 0;
    mismatches = 0;
    in_quiet   = 1'b0;
    cam_x      = 16'sd0;
    s_min      = 16'sd0;
    s_max      = vspf_pkg::SINE_MAX_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: load_thresholds(16'h8000, 16'(-16384), 16'd16384);
          2: load_thresholds(16'h7FFF, 16'd16384, 16'd16384);
          // Thresholds beyond one are taken as they are.
          3: load_thresholds(16'd0, 16'h8000, 16'h7FFF);
          4: begin
            smin_i = $urandom_range(0, 24384) - 16384;
            smax_i = $urandom_range(smin_i + 16384, 32768) - 16384;
            load_thresholds(16'($urandom_range(0, 6000)) - 16'd3000, 16'(smin_i),
                            16'(smax_i));
          end
          5: load_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
          default: load_thresholds(16'($urandom), 16'(-11585), 16'd11585);
        endcase
      end
      if (ph == 0) run_directed();
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 85) run_frame();
        else run_noise();
      end
    end
    settle();
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
